### src/pcrd_pkg.sv
`timescale 1ns / 1ps
// Package for the PCI capability register decode unit.
// Holds the access, configuration and register types, the window constants and the
// window hit function. Depends on nothing.
package pcrd_pkg;

    localparam int unsigned ADDR_W = 12;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned SIZE_W = 3;

    localparam logic [15:0] MSIX_CTRL_MASK  = 16'hC7FF;
    localparam logic [15:0] PM_CTRL_MASK    = 16'h8103;
    localparam logic [2:0]  PASID_CTRL_MASK = 3'h7;
    localparam logic [15:0] HALF_MASK       = 16'hFFFF;

    localparam logic [7:0] PCIE_WIN_SIZE     = 8'd60;
    localparam logic [7:0] MSIX_WIN_SIZE     = 8'd12;
    localparam logic [7:0] PM_WIN_SIZE       = 8'd8;
    localparam logic [7:0] PASID_WIN_SIZE    = 8'd8;
    localparam logic [7:0] MSI_WIN_BASE_SIZE = 8'd12;
    localparam logic [7:0] VSEC_SIZE_RESET   = 8'd8;

    localparam logic [SIZE_W-1:0] SIZE_HALF = 3'd2;
    localparam logic [SIZE_W-1:0] SIZE_WORD = 3'd4;

    typedef enum logic [2:0] {
        CFG_MSI_BASE   = 3'd0,
        CFG_MSI_MODE   = 3'd1,
        CFG_MSIX_BASE  = 3'd2,
        CFG_PM_BASE    = 3'd3,
        CFG_PASID_BASE = 3'd4,
        CFG_PCIE_BASE  = 3'd5,
        CFG_VSEC_BASE  = 3'd6,
        CFG_VSEC_SIZE  = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic [DATA_W-1:0] wdata;
    } access_t;

    typedef struct packed {
        logic [7:0] msi_base;
        logic [1:0] msi_mode;
        logic [7:0] msix_base;
        logic [7:0] pm_base;
        logic [7:0] pasid_base;
        logic [7:0] pcie_base;
        logic [7:0] vsec_base;
        logic [7:0] vsec_size;
    } cfg_t;

    typedef struct packed {
        logic [15:0] msi_control;
        logic [31:0] msi_address_low;
        logic [31:0] msi_address_high;
        logic [15:0] msi_data;
        logic [31:0] msi_mask;
        logic [15:0] msix_control;
        logic [15:0] pm_control;
        logic [2:0]  pasid_control;
    } cap_state_t;

    typedef struct packed {
        logic              handled;
        logic [DATA_W-1:0] rdata;
    } result_t;

    // True when the address falls inside a window placed at a non-zero base.
    function automatic logic in_window(input logic [ADDR_W-1:0] addr,
                                       input logic [7:0] base,
                                       input logic [7:0] size);
        logic [ADDR_W:0] lo;
        logic [ADDR_W:0] hi;
        logic [ADDR_W:0] a;
        lo = {{(ADDR_W-7){1'b0}}, base};
        hi = lo + {{(ADDR_W-7){1'b0}}, size};
        a  = {1'b0, addr};
        return (base != 8'd0) && (a >= lo) && (a < hi);
    endfunction

endpackage

### src/pcrd_decode.sv
`timescale 1ns / 1ps
// Window decode and register access logic for one configuration access.
// Purely combinational; uses pcrd_pkg for its types and constants.
module pcrd_decode
    import pcrd_pkg::*;
(
    input  access_t    item,
    input  cfg_t       cfg,
    input  cap_state_t cur,
    output cap_state_t nxt,
    output result_t    result
);

    logic       is64;
    logic       masking;
    logic [7:0] msi_size;
    logic [7:0] data_off;
    logic [7:0] mask_off;
    logic       hit_msi;
    logic       hit_msix;
    logic       hit_pm;
    logic       hit_pasid;
    logic       hit_other;
    logic [7:0] off_msi;
    logic [7:0] off_msix;
    logic [7:0] off_pm;
    logic [7:0] off_pasid;
    logic       sz_half;
    logic       sz_word;

    assign is64     = cfg.msi_mode[0];
    assign masking  = cfg.msi_mode[1];
    assign msi_size = MSI_WIN_BASE_SIZE + (is64 ? 8'd4 : 8'd0) + (masking ? 8'd8 : 8'd0);
    assign data_off = is64 ? 8'd12 : 8'd8;
    assign mask_off = is64 ? 8'd16 : 8'd12;

    assign hit_msi   = in_window(item.addr, cfg.msi_base, msi_size);
    assign hit_msix  = in_window(item.addr, cfg.msix_base, MSIX_WIN_SIZE);
    assign hit_pm    = in_window(item.addr, cfg.pm_base, PM_WIN_SIZE);
    assign hit_pasid = in_window(item.addr, cfg.pasid_base, PASID_WIN_SIZE);
    assign hit_other = in_window(item.addr, cfg.pcie_base, PCIE_WIN_SIZE)
                     | in_window(item.addr, cfg.vsec_base, cfg.vsec_size);

    // Inside a window the offset is below 255, so the low byte is exact.
    assign off_msi   = item.addr[7:0] - cfg.msi_base;
    assign off_msix  = item.addr[7:0] - cfg.msix_base;
    assign off_pm    = item.addr[7:0] - cfg.pm_base;
    assign off_pasid = item.addr[7:0] - cfg.pasid_base;

    assign sz_half = (item.size == SIZE_HALF);
    assign sz_word = (item.size == SIZE_WORD);

    always_comb
    begin
        nxt            = cur;
        result.handled = 1'b0;
        result.rdata   = '0;
        if (hit_msi)
        begin
            if (item.wr)
            begin
                result.handled = 1'b1;
                if (off_msi == 8'd2 && sz_half)
                    nxt.msi_control = item.wdata[15:0] & HALF_MASK;
                else if (off_msi == 8'd4 && sz_word)
                    nxt.msi_address_low = item.wdata;
                else if (is64 && off_msi == 8'd8 && sz_word)
                    nxt.msi_address_high = item.wdata;
                else if (off_msi == data_off && sz_half)
                    nxt.msi_data = item.wdata[15:0] & HALF_MASK;
                else if (masking && off_msi == mask_off && sz_word)
                    nxt.msi_mask = item.wdata;
            end
            else
            begin
                if (off_msi == 8'd2 && sz_half)
                begin
                    result.handled = 1'b1;
                    result.rdata   = {16'd0, cur.msi_control};
                end
                else if (off_msi == 8'd4)
                begin
                    result.handled = 1'b1;
                    result.rdata   = cur.msi_address_low;
                end
                else if (is64 && off_msi == 8'd8)
                begin
                    result.handled = 1'b1;
                    result.rdata   = cur.msi_address_high;
                end
                else if (off_msi == data_off)
                begin
                    result.handled = 1'b1;
                    result.rdata   = {16'd0, cur.msi_data};
                end
            end
        end
        else if (hit_msix)
        begin
            if (item.wr)
            begin
                result.handled = 1'b1;
                if (off_msix == 8'd2 && sz_half)
                    nxt.msix_control = item.wdata[15:0] & MSIX_CTRL_MASK;
            end
            else if (off_msix == 8'd2 && sz_half)
            begin
                result.handled = 1'b1;
                result.rdata   = {16'd0, cur.msix_control};
            end
        end
        else if (hit_pm)
        begin
            if (item.wr)
            begin
                result.handled = 1'b1;
                if (off_pm == 8'd4 && sz_half)
                    nxt.pm_control = item.wdata[15:0] & PM_CTRL_MASK;
            end
            else if (off_pm == 8'd4 && sz_half)
            begin
                result.handled = 1'b1;
                result.rdata   = {16'd0, cur.pm_control};
            end
        end
        else if (hit_pasid)
        begin
            if (item.wr)
            begin
                result.handled = 1'b1;
                if (off_pasid == 8'd4 && sz_half)
                    nxt.pasid_control = item.wdata[2:0] & PASID_CTRL_MASK;
            end
            else if (off_pasid == 8'd4 && sz_half)
            begin
                result.handled = 1'b1;
                result.rdata   = {29'd0, cur.pasid_control};
            end
        end
        else if (hit_other)
        begin
            result.handled = item.wr;
        end
    end

endmodule

### src/pci_capability_register_decode_unit.sv
`timescale 1ns / 1ps
// PCI capability register decode unit: top level with handshakes, registers and config port.
// Uses pcrd_pkg and pcrd_decode.
// Path: an accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle unless the output stalls; decode and update are combinational.
// Reset: configuration returns to zero bases, MSI mode 0 and a vendor window of 8 bytes,
// all capability registers clear to zero and both stages empty.
module pci_capability_register_decode_unit
    import pcrd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,   // address[11:0], access_size[14:12], write_data[46:15], zero
    input  logic              s_tuser,   // func
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // read_data[31:0]
    output logic              m_tuser,   // handled
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [7:0]        cfg_data
);

    logic       in_valid_reg;
    access_t    in_item_reg;
    logic       out_valid_reg;
    result_t    out_result_reg;
    cfg_t       cfg_reg;
    cap_state_t state_reg;
    cap_state_t state_next;
    result_t    result_next;
    logic       out_free;
    logic       advance;
    logic       accept;
    cfg_index_t cfg_sel;

    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_sel   = cfg_index_t'(cfg_index);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_result_reg.rdata;
    assign m_tuser  = out_result_reg.handled;

    pcrd_decode u_decode
    (
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .nxt    (state_next),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg.wr    <= s_tuser;
            in_item_reg.addr  <= s_tdata[11:0];
            in_item_reg.size  <= s_tdata[14:12];
            in_item_reg.wdata <= s_tdata[46:15];
        end
        if (advance)
            out_result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{msi_base: 8'd0, msi_mode: 2'd0, msix_base: 8'd0, pm_base: 8'd0,
                         pasid_base: 8'd0, pcie_base: 8'd0, vsec_base: 8'd0,
                         vsec_size: VSEC_SIZE_RESET};
        end
        else if (cfg_valid)
        begin
            unique case (cfg_sel)
                CFG_MSI_BASE:   cfg_reg.msi_base   <= cfg_data;
                CFG_MSI_MODE:   cfg_reg.msi_mode   <= cfg_data[1:0];
                CFG_MSIX_BASE:  cfg_reg.msix_base  <= cfg_data;
                CFG_PM_BASE:    cfg_reg.pm_base    <= cfg_data;
                CFG_PASID_BASE: cfg_reg.pasid_base <= cfg_data;
                CFG_PCIE_BASE:  cfg_reg.pcie_base  <= cfg_data;
                CFG_VSEC_BASE:  cfg_reg.vsec_base  <= cfg_data;
                CFG_VSEC_SIZE:  cfg_reg.vsec_size  <= cfg_data;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

endmodule

### src/pcrd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the PCI capability register decode unit, with its bind statement.
// Uses pcrd_pkg for widths.
module pcrd_checker
    import pcrd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic              m_tuser,
    input logic              cfg_valid,
    input logic              cfg_ready
);

    // A stalled result item holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // An item that is not handled carries zero data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("unhandled item carries non-zero data");

    // With the result register empty the input side must take items.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // Configuration writes are never held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind pci_capability_register_decode_unit pcrd_checker u_pcrd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
